### src/tcs_pkg.sv
// Package for the tick-driven CPU scheduler: sizes, codes and shared types.
// Used by the channel interfaces and by every module of the scheduler.
package tcs_pkg;

	// Slot count and derived index widths.
	localparam int NUM_SLOTS  = 4;
	localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int FREE_W     = $clog2(NUM_SLOTS + 1);

	// Field widths.
	localparam int WORK_W     = 16;
	localparam int WAIT_W     = 32;
	localparam int QUANT_W    = 8;
	localparam int MODE_W     = 2;
	localparam int OSLOT_W    = 2;
	localparam int SUM_W      = WAIT_W + $clog2(NUM_SLOTS);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// Scheduling policies.
	typedef enum logic [MODE_W-1:0] {
		MODE_RR   = 2'd0,
		MODE_FCFS = 2'd1,
		MODE_SJF  = 2'd2,
		MODE_SRTF = 2'd3
	} policy_t;

	// Request action codes.
	localparam logic ACT_TICK    = 1'b0;
	localparam logic ACT_ARRIVAL = 1'b1;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_QUANTUM = 1'd1;
	localparam logic [QUANT_W-1:0]   QUANT_DEFAULT    = 8'd4;

	typedef logic [SLOT_W-1:0]                  slot_t;
	typedef logic [NUM_SLOTS-1:0][WORK_W-1:0]   work_arr_t;
	typedef logic [NUM_SLOTS-1:0][WAIT_W-1:0]   wait_arr_t;

	// Selection handed from the picker to the state block.
	typedef struct packed {
		slot_t slot;
		logic  reload;
	} pick_t;

	// One result item.
	typedef struct packed {
		logic [OSLOT_W-1:0] running_slot;
		logic [WORK_W-1:0]  running_left;
		logic               switched;
		logic               all_done;
		logic               arrival_dropped;
		logic [WAIT_W-1:0]  total_wait;
	} rsp_t;

endpackage

### src/tcs_if.sv
// Valid/ready channel interfaces for scheduler requests and results.
// Depends on tcs_pkg for the field widths.
interface tcs_req_if;
	import tcs_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [WORK_W-1:0] burst_length;

	modport source (output valid, output action, output burst_length, input ready);
	modport sink (input valid, input action, input burst_length, output ready);
endinterface

interface tcs_rsp_if;
	import tcs_pkg::*;

	logic               valid;
	logic               ready;
	logic [OSLOT_W-1:0] running_slot;
	logic [WORK_W-1:0]  running_left;
	logic               switched;
	logic               all_done;
	logic               arrival_dropped;
	logic [WAIT_W-1:0]  total_wait;

	modport source (output valid, output running_slot, output running_left, output switched,
		output all_done, output arrival_dropped, output total_wait, input ready);
	modport sink (input valid, input running_slot, input running_left, input switched,
		input all_done, input arrival_dropped, input total_wait, output ready);
endinterface

### src/tick_cpu_scheduler.sv
// Tick-driven CPU scheduler top level: request register, state update, result register.
// An accepted request is held in the input register and moves into the result register when
// that register is free or being emptied; throughput is one request per cycle while rsp.ready stays high.
// Reset (arst_n low) clears all slots, wait counters, the current slot and the quantum,
// and sets policy_mode to first come first served and time_quantum to 4.
// Depends on tcs_pkg, tcs_if and tcs_core.
module tick_cpu_scheduler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcs_pkg::CFG_DATA_W-1:0]    cfg_data,
	tcs_req_if.sink                           req,
	tcs_rsp_if.source                         rsp
);
	import tcs_pkg::*;

	policy_t            mode_q;
	logic [QUANT_W-1:0] quantum_q;
	logic               valid_s1;
	logic               action_s1;
	logic [WORK_W-1:0]  burst_s1;
	logic               advance;
	logic               out_valid_q;
	rsp_t               core_rsp;
	rsp_t               rsp_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_FCFS;
			quantum_q <= QUANT_DEFAULT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POLICY_MODE:  mode_q    <= policy_t'(cfg_data[MODE_W-1:0]);
				CFG_TIME_QUANTUM: quantum_q <= cfg_data[QUANT_W-1:0];
				default:          mode_q    <= mode_q;
			endcase
		end
	end

	// The held request moves on when the result register is free or being emptied.
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.action;
			burst_s1  <= req.burst_length;
		end
	end

	tcs_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.action       (action_s1),
		.burst_length (burst_s1),
		.mode         (mode_q),
		.quantum      (quantum_q),
		.rsp          (core_rsp)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= core_rsp;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.running_slot    = rsp_q.running_slot;
	assign rsp.running_left    = rsp_q.running_left;
	assign rsp.switched        = rsp_q.switched;
	assign rsp.all_done        = rsp_q.all_done;
	assign rsp.arrival_dropped = rsp_q.arrival_dropped;
	assign rsp.total_wait      = rsp_q.total_wait;

endmodule

### src/tcs_pick.sv
// Slot selection for one tick under the active scheduling policy.
// Depends on tcs_pkg; purely combinational.
module tcs_pick (
	input  tcs_pkg::policy_t              mode,
	input  tcs_pkg::work_arr_t            work,
	input  tcs_pkg::slot_t                cur,
	input  logic [tcs_pkg::QUANT_W-1:0]   quantum_left,
	output tcs_pkg::pick_t                pick
);
	import tcs_pkg::*;

	logic [NUM_SLOTS-1:0] busy;
	slot_t                rr_same;
	slot_t                rr_next;
	slot_t                lowest;
	slot_t                shortest;

	// First busy slot searching cyclically from start (start is at most NUM_SLOTS).
	function automatic slot_t first_cyclic(input logic [SLOT_W:0] start,
		input logic [NUM_SLOTS-1:0] b);
		logic [SLOT_W:0] idx;
		slot_t           res;
		if (start >= (SLOT_W+1)'(NUM_SLOTS)) begin
			idx = start - (SLOT_W+1)'(NUM_SLOTS);
		end else begin
			idx = start;
		end
		res = idx[SLOT_W-1:0];
		for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
			idx = start + (SLOT_W+1)'(k);
			if (idx >= (SLOT_W+1)'(NUM_SLOTS)) begin
				idx = idx - (SLOT_W+1)'(NUM_SLOTS);
			end
			if (b[idx[SLOT_W-1:0]]) begin
				res = idx[SLOT_W-1:0];
			end
		end
		return res;
	endfunction

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			busy[i] = (work[i] != '0);
		end
	end

	// Cyclic searches for round robin and the lowest busy slot for FCFS.
	assign rr_same = first_cyclic({1'b0, cur}, busy);
	assign rr_next = first_cyclic({1'b0, cur} + (SLOT_W+1)'(1), busy);
	assign lowest  = first_cyclic('0, busy);

	// Least remaining work among busy slots; ties keep the lower index.
	always_comb begin
		logic [WORK_W:0] best_v;
		best_v   = {1'b1, {WORK_W{1'b0}}};
		shortest = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (busy[i] && ({1'b0, work[i]} < best_v)) begin
				best_v   = {1'b0, work[i]};
				shortest = SLOT_W'(i);
			end
		end
	end

	// Policy decision.
	always_comb begin
		pick.slot   = cur;
		pick.reload = 1'b0;
		unique case (mode)
			MODE_RR: begin
				if (!busy[cur]) begin
					pick.slot   = rr_same;
					pick.reload = 1'b1;
				end else if (quantum_left == '0) begin
					pick.slot   = rr_next;
					pick.reload = 1'b1;
				end
			end
			MODE_FCFS: begin
				if (!busy[cur]) begin
					pick.slot = lowest;
				end
			end
			MODE_SJF: begin
				if (!busy[cur]) begin
					pick.slot = shortest;
				end
			end
			MODE_SRTF: begin
				pick.slot = shortest;
			end
			default: begin
				pick.slot = cur;
			end
		endcase
	end

endmodule

### src/tcs_core.sv
// Scheduler state (slot work, wait counters, current slot, quantum) and its update.
// Depends on tcs_pkg and tcs_pick; forms one result from the request at its input.
module tcs_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          action,
	input  logic [tcs_pkg::WORK_W-1:0]    burst_length,
	input  tcs_pkg::policy_t              mode,
	input  logic [tcs_pkg::QUANT_W-1:0]   quantum,
	output tcs_pkg::rsp_t                 rsp
);
	import tcs_pkg::*;

	work_arr_t          work_q;
	work_arr_t          work_n;
	wait_arr_t          wait_q;
	wait_arr_t          wait_n;
	slot_t              cur_q;
	slot_t              cur_n;
	logic [QUANT_W-1:0] ql_q;
	logic [QUANT_W-1:0] ql_n;
	logic [QUANT_W-1:0] eff_q;
	logic [QUANT_W-1:0] ql_base;
	logic [FREE_W-1:0]  free_q;
	logic [FREE_W-1:0]  free_n;
	logic               any_work;
	logic               any_left;
	logic               switched;
	logic               dropped;
	logic [SUM_W-1:0]   wait_sum;
	logic [SLOT_W+1:0]  cur_ext;
	pick_t              pick;

	tcs_pick u_pick (
		.mode         (mode),
		.work         (work_q),
		.cur          (cur_q),
		.quantum_left (ql_q),
		.pick         (pick)
	);

	always_comb begin
		any_work = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			any_work = any_work | (work_q[i] != '0);
		end
	end

	// A quantum of zero behaves as one.
	assign eff_q   = (quantum == '0) ? QUANT_W'(1) : quantum;
	assign ql_base = pick.reload ? eff_q : ql_q;

	// Next state for an arrival or a tick.
	always_comb begin
		work_n   = work_q;
		wait_n   = wait_q;
		cur_n    = cur_q;
		ql_n     = ql_q;
		free_n   = free_q;
		switched = 1'b0;
		dropped  = 1'b0;
		if (action == ACT_ARRIVAL) begin
			if (free_q < FREE_W'(NUM_SLOTS)) begin
				if (!any_work) begin
					ql_n = eff_q;
				end
				work_n[free_q[SLOT_W-1:0]] = burst_length;
				free_n = free_q + FREE_W'(1);
			end else begin
				dropped = 1'b1;
			end
		end else if (any_work) begin
			if (mode == MODE_RR) begin
				ql_n = ql_base - QUANT_W'(1);
			end
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if ((SLOT_W'(i) != pick.slot) && (work_q[i] != '0) && (wait_q[i] != '1)) begin
					wait_n[i] = wait_q[i] + WAIT_W'(1);
				end
			end
			work_n[pick.slot] = work_q[pick.slot] - WORK_W'(1);
			switched = (pick.slot != cur_q);
			cur_n    = pick.slot;
		end
	end

	// Result fields taken from the updated state.
	always_comb begin
		any_left = 1'b0;
		wait_sum = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			any_left = any_left | (work_n[i] != '0);
			wait_sum = wait_sum + SUM_W'(wait_n[i]);
		end
	end

	assign cur_ext = {2'b00, cur_n};

	always_comb begin
		rsp.running_slot    = cur_ext[OSLOT_W-1:0];
		rsp.running_left    = work_n[cur_n];
		rsp.switched        = switched;
		rsp.all_done        = !any_left;
		rsp.arrival_dropped = dropped;
		rsp.total_wait      = (wait_sum > SUM_W'({WAIT_W{1'b1}})) ? '1 : wait_sum[WAIT_W-1:0];
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q <= '0;
			wait_q <= '0;
			cur_q  <= '0;
			ql_q   <= '0;
			free_q <= '0;
		end else if (en) begin
			work_q <= work_n;
			wait_q <= wait_n;
			cur_q  <= cur_n;
			ql_q   <= ql_n;
			free_q <= free_n;
		end
	end

endmodule

### dv/tb_top.sv
// Self-checking testbench for tick_cpu_scheduler: directed and randomized requests,
// an in-line prediction of the scheduler state and an in-order result check.
// Depends on tcs_pkg, tcs_if (request and result channels) and the scheduler RTL.
`timescale 1ns / 1ps

module tb_top;
	import tcs_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tcs_req_if req_ch ();
	tcs_rsp_if rsp_ch ();

	tick_cpu_scheduler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch.sink),
		.rsp       (rsp_ch.source)
	);

	// Predicted scheduler state and configuration.
	logic [WORK_W-1:0]  slot_work [NUM_SLOTS];
	logic [WAIT_W-1:0]  slot_wait [NUM_SLOTS];
	int                 cur_slot;
	logic [QUANT_W-1:0] quantum_left;
	int                 next_free;
	policy_t            sched_mode;
	logic [QUANT_W-1:0] sched_quantum;

	rsp_t pending_results [$];
	int   fail_count;
	int   src_idle_pct;
	int   snk_stall_pct;

	// Clock with a 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// True when any slot still holds work.
	function automatic logic has_work();
		for (int i = 0; i < NUM_SLOTS; i++)
			if (slot_work[i] != '0)
				return 1'b1;
		return 1'b0;
	endfunction

	// A programmed quantum of zero behaves as one.
	function automatic logic [QUANT_W-1:0] active_quantum();
		return (sched_quantum == '0) ? QUANT_W'(1) : sched_quantum;
	endfunction

	// First slot with work, scanning cyclically from the given slot.
	function automatic int first_with_work(input int start);
		int s;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			s = (start + k) % NUM_SLOTS;
			if (slot_work[s] != '0)
				return s;
		end
		return start % NUM_SLOTS;
	endfunction

	// Slot with the least remaining work; ties go to the lowest index.
	function automatic int least_work();
		int              best;
		logic [WORK_W:0] best_val;
		best = 0;
		best_val = {1'b1, {WORK_W{1'b0}}};
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (slot_work[i] != '0 && {1'b0, slot_work[i]} < best_val) begin
				best_val = {1'b0, slot_work[i]};
				best = i;
			end
		end
		return best;
	endfunction

	// Applies one request to the predicted state and returns the expected result.
	function automatic rsp_t schedule_item(input logic act, input logic [WORK_W-1:0] burst);
		rsp_t            r;
		int              cur;
		int              pick;
		logic            sw;
		logic            dropped;
		logic [WAIT_W+2:0] wait_sum;
		cur = cur_slot % NUM_SLOTS;
		sw = 1'b0;
		dropped = 1'b0;
		if (act == ACT_ARRIVAL) begin
			if (next_free < NUM_SLOTS) begin
				// A job arriving at an empty machine starts with a full quantum.
				if (!has_work())
					quantum_left = active_quantum();
				slot_work[next_free] = burst;
				next_free++;
			end else begin
				dropped = 1'b1;
			end
		end else if (has_work()) begin
			pick = cur;
			case (sched_mode)
				MODE_RR: begin
					if (slot_work[cur] == '0) begin
						pick = first_with_work(cur);
						quantum_left = active_quantum();
					end else if (quantum_left == '0) begin
						pick = first_with_work(cur + 1);
						quantum_left = active_quantum();
					end
					quantum_left = quantum_left - 1'b1;
				end
				MODE_FCFS: begin
					if (slot_work[cur] == '0)
						pick = first_with_work(0);
				end
				MODE_SJF: begin
					if (slot_work[cur] == '0)
						pick = least_work();
				end
				default: begin
					pick = least_work();
				end
			endcase
			// Every other slot with work waits one more tick.
			for (int i = 0; i < NUM_SLOTS; i++)
				if (i != pick && slot_work[i] != '0 && slot_wait[i] != '1)
					slot_wait[i]++;
			slot_work[pick]--;
			sw = (pick != cur);
			cur = pick;
			cur_slot = pick;
		end
		wait_sum = '0;
		for (int i = 0; i < NUM_SLOTS; i++)
			wait_sum += slot_wait[i];
		r.running_slot = OSLOT_W'(cur);
		r.running_left = slot_work[cur];
		r.switched = sw;
		r.all_done = !has_work();
		r.arrival_dropped = dropped;
		r.total_wait = (wait_sum > {3'b000, {WAIT_W{1'b1}}}) ? '1 : wait_sum[WAIT_W-1:0];
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [WAIT_W-1:0] want,
		input logic [WAIT_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Result check against the oldest expectation.
	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("running_slot", want.running_slot, rsp_ch.running_slot);
				check_field("running_left", want.running_left, rsp_ch.running_left);
				check_field("switched", want.switched, rsp_ch.switched);
				check_field("all_done", want.all_done, rsp_ch.all_done);
				check_field("arrival_dropped", want.arrival_dropped, rsp_ch.arrival_dropped);
				check_field("total_wait", want.total_wait, rsp_ch.total_wait);
			end
		end
	end

	// Result back-pressure.
	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99, 0) >= snk_stall_pct);

	// Sends one request; entered and left at a falling edge. Valid stays high after
	// acceptance so back-to-back requests need no extra toggle.
	task automatic send_request(input logic act, input logic [WORK_W-1:0] burst);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.action = act;
		req_ch.burst_length = burst;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_results.push_back(schedule_item(act, burst));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Register write; only issued with nothing in flight.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		if (idx == CFG_POLICY_MODE)
			sched_mode = policy_t'(data[MODE_W-1:0]);
		else
			sched_quantum = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Ticks on an empty machine after reset.
	task automatic test_idle_tick();
		send_request(ACT_TICK, '1);
		send_request(ACT_TICK, '0);
	endtask

	// Fill every slot under round robin with a zero quantum: a zero burst, two equal
	// jobs that tie, and one job of the largest size.
	task automatic test_first_jobs();
		logic [WORK_W-1:0] burst;
		burst = WORK_W'($urandom_range(900, 300));
		wait_drained();
		write_register(CFG_POLICY_MODE, CFG_DATA_W'(MODE_RR));
		write_register(CFG_TIME_QUANTUM, '0);
		send_request(ACT_ARRIVAL, '0);
		send_request(ACT_TICK, WORK_W'($urandom()));
		send_request(ACT_ARRIVAL, burst);
		repeat (3) send_request(ACT_TICK, WORK_W'($urandom()));
		send_request(ACT_ARRIVAL, burst);
		repeat (4) send_request(ACT_TICK, WORK_W'($urandom()));
		send_request(ACT_ARRIVAL, '1);
		repeat (3) send_request(ACT_TICK, WORK_W'($urandom()));
	endtask

	// Arrivals with all slots taken are dropped.
	task automatic test_full_slots();
		send_request(ACT_ARRIVAL, '1);
		send_request(ACT_ARRIVAL, '0);
		send_request(ACT_ARRIVAL, WORK_W'($urandom()));
		repeat (2) send_request(ACT_TICK, WORK_W'($urandom()));
	endtask

	// Random ticks with a few dropped arrivals, over eight phases that vary policy, quantum and idling mix.
	task automatic test_random_policies();
		policy_t            phase_mode [8];
		logic [QUANT_W-1:0] phase_quantum [8];
		int                 ticks;
		phase_mode = '{MODE_RR, MODE_FCFS, MODE_SJF, MODE_SRTF,
			MODE_RR, MODE_FCFS, MODE_RR, MODE_SRTF};
		phase_quantum = '{8'd1, 8'd0, QUANT_W'($urandom()), 8'd255,
			8'd255, QUANT_W'($urandom()), QUANT_W'($urandom_range(12, 2)), 8'd1};
		for (int p = 0; p < 8; p++) begin
			wait_drained();
			write_register(CFG_POLICY_MODE, CFG_DATA_W'(phase_mode[p]));
			write_register(CFG_TIME_QUANTUM, phase_quantum[p]);
			case (p / 2)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 63; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 63; end
				default: begin src_idle_pct = 12; snk_stall_pct = 12; end
			endcase
			ticks = 0;
			while (ticks < 175) begin
				if ($urandom_range(99, 0) < 8) begin
					send_request(ACT_ARRIVAL, WORK_W'($urandom()));
				end else begin
					send_request(ACT_TICK, WORK_W'($urandom()));
					ticks++;
				end
			end
		end
	endtask

	// Predictor reset, stimulus sequence and final verdict.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_TICK;
		req_ch.burst_length = '0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		fail_count = 0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_work[i] = '0;
			slot_wait[i] = '0;
		end
		cur_slot = 0;
		quantum_left = '0;
		next_free = 0;
		sched_mode = MODE_FCFS;
		sched_quantum = QUANT_DEFAULT;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_idle_tick();
		test_first_jobs();
		test_full_slots();
		test_random_policies();

		wait_drained();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#(400_000 * 12);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
